// ===== rtl/core/mpfp_pkg.sv =====
// Package: shared types and constants of the motor position frame parser.
`timescale 1ns / 1ps

package mpfp_pkg;

  // Item kinds carried in the input tuser field
  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_BYTE  = 2'd1,
    FUNC_TICK  = 2'd2
  } func_e;

  // Configuration register indexes
  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_TIMEOUT_LIMIT  = 1'b1;

  // Result status codes
  localparam logic STATUS_FRAME   = 1'b0;
  localparam logic STATUS_TIMEOUT = 1'b1;

  localparam int unsigned PosWidth     = 33;
  localparam int unsigned OutDataWidth = 40;

  localparam logic [7:0]  AddressReset = 8'd1;
  localparam logic [15:0] TimeoutReset = 16'd100;

  // One input item as held in the input register
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
  } item_t;

  // One result item
  typedef struct packed {
    logic                       status;
    logic signed [PosWidth-1:0] position_tenths;
  } result_t;

endpackage

// ===== rtl/core/mpfp_in_stage.sv =====
// Input register stage: holds one accepted item until the parser takes it.
`timescale 1ns / 1ps

module mpfp_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  mpfp_pkg::item_t item_i,
  output logic           valid_o,
  input  logic           take_i,
  output mpfp_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  mpfp_pkg::item_t item_q;

  // Free when empty or when the held item leaves this cycle
  assign ready_o = !valid_q || take_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== rtl/core/mpfp_hunter.sv =====
// Frame hunter: search state, timeout counter and configuration registers.
`timescale 1ns / 1ps

module mpfp_hunter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_write_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               take_i,
  input  mpfp_pkg::item_t    item_i,
  output logic               res_valid_o,
  output mpfp_pkg::result_t  res_o
);

  localparam logic [7:0] MarkCommand = 8'h36;
  localparam logic [7:0] MarkEnd     = 8'h6B;

  localparam logic [2:0] IdxAddress = 3'd0;
  localparam logic [2:0] IdxCommand = 3'd1;
  localparam logic [2:0] IdxSign    = 3'd2;
  localparam logic [2:0] IdxPos0    = 3'd3;
  localparam logic [2:0] IdxPos1    = 3'd4;
  localparam logic [2:0] IdxPos2    = 3'd5;
  localparam logic [2:0] IdxPos3    = 3'd6;
  localparam logic [2:0] IdxEnd     = 3'd7;

  logic [7:0]  address_q;
  logic [15:0] limit_q;

  logic        searching_q, searching_d;
  logic [2:0]  index_q, index_d;
  logic        sign_q, sign_d;
  logic [31:0] shift_q, shift_d;
  logic [15:0] elapsed_q, elapsed_d;

  logic [7:0]  b;
  logic [32:0] mag;

  assign b   = item_i.rx_byte;
  assign mag = {1'b0, shift_q};

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      address_q <= mpfp_pkg::AddressReset;
      limit_q   <= mpfp_pkg::TimeoutReset;
    end else if (cfg_write_i) begin
      unique case (cfg_index_i)
        mpfp_pkg::CFG_DEVICE_ADDRESS: address_q <= cfg_data_i[7:0];
        mpfp_pkg::CFG_TIMEOUT_LIMIT:  limit_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next state and result for the item in the input register
  always_comb begin
    searching_d = searching_q;
    index_d     = index_q;
    sign_d      = sign_q;
    shift_d     = shift_q;
    elapsed_d   = elapsed_q;
    res_valid_o = 1'b0;
    res_o.status          = mpfp_pkg::STATUS_FRAME;
    res_o.position_tenths = sign_q ? $signed(33'd0 - mag) : $signed(mag);

    unique case (mpfp_pkg::func_e'(item_i.func))
      mpfp_pkg::FUNC_START: begin
        searching_d = 1'b1;
        index_d     = IdxAddress;
        sign_d      = 1'b0;
        shift_d     = '0;
        elapsed_d   = '0;
      end
      mpfp_pkg::FUNC_BYTE: begin
        if (searching_q) begin
          unique case (index_q)
            IdxAddress: begin
              if (b == address_q) index_d = IdxCommand;
            end
            IdxCommand: begin
              if (b == MarkCommand) index_d = IdxSign;
              else if (b == address_q) index_d = IdxCommand;
              else index_d = IdxAddress;
            end
            IdxSign: begin
              sign_d  = (b != 8'd0);
              index_d = IdxPos0;
            end
            IdxPos0, IdxPos1, IdxPos2, IdxPos3: begin
              shift_d = {shift_q[23:0], b};
              index_d = index_q + 3'd1;
            end
            IdxEnd: begin
              // Good terminator ends the search; a bad one drops the frame
              if (b == MarkEnd) begin
                res_valid_o = 1'b1;
                searching_d = 1'b0;
              end
              index_d = IdxAddress;
              sign_d  = 1'b0;
              shift_d = '0;
            end
            default: ;
          endcase
        end
      end
      mpfp_pkg::FUNC_TICK: begin
        if (searching_q) begin
          if (elapsed_q != 16'hFFFF) elapsed_d = elapsed_q + 16'd1;
          if (elapsed_d >= limit_q) begin
            res_valid_o           = 1'b1;
            res_o.status          = mpfp_pkg::STATUS_TIMEOUT;
            res_o.position_tenths = '0;
            searching_d           = 1'b0;
            index_d               = IdxAddress;
            sign_d                = 1'b0;
            shift_d               = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      searching_q <= 1'b0;
      index_q     <= IdxAddress;
      sign_q      <= 1'b0;
      shift_q     <= '0;
      elapsed_q   <= '0;
    end else if (take_i) begin
      searching_q <= searching_d;
      index_q     <= index_d;
      sign_q      <= sign_d;
      shift_q     <= shift_d;
      elapsed_q   <= elapsed_d;
    end
  end

endmodule

// ===== rtl/core/mpfp_out_stage.sv =====
// Result register: holds one result item until the downstream side takes it.
`timescale 1ns / 1ps

module mpfp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              res_valid_i,
  input  mpfp_pkg::result_t res_i,
  output logic              ready_o,
  output logic              valid_o,
  input  logic              ready_i,
  output mpfp_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  mpfp_pkg::result_t res_q;

  // Can load when empty or when the held result is taken this cycle
  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? (load_i && res_valid_i) : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== rtl/core/motor_position_frame_parser.sv =====
// Top level: motor position reply parser with stream ports and config port.
`timescale 1ns / 1ps

// Takes one item per clock cycle, back to back, when the output side is not
// stalled; an item is held in the input register and its result in the result
// register. A start item (tuser 0) arms the hunt and clears the millisecond
// count; byte items (tuser 1) feed the frame hunter; tick items (tuser 2)
// count toward the configured timeout. A search that ends gives exactly one
// result: a signed position in tenths of a degree (status 0) or a timeout
// (status 1, position zero); a start item restarts a search without a result.
// Bytes and ticks while idle are dropped, as is tuser 3. Configuration
// writes are taken at once and must only be made while the block is idle.

module motor_position_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,   // 0 device_address, 1 timeout_limit_ms
  input  logic [15:0] cfg_data_i,
  // Input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] func
  // Result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [32:0] position_tenths, [39:33] zero
  output logic [0:0]  m_axis_tuser_o    // [0] status
);

  mpfp_pkg::item_t   in_item, held_item;
  mpfp_pkg::result_t res, out_res;
  logic              held_valid, take, out_ready, res_valid;

  assign cfg_ready_o = 1'b1;

  assign in_item.func    = s_axis_tuser_i;
  assign in_item.rx_byte = s_axis_tdata_i;

  mpfp_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .valid_o (held_valid),
    .take_i  (take),
    .item_o  (held_item)
  );

  // Item moves on when the result register can take its result
  assign take = held_valid && out_ready;

  mpfp_hunter u_hunter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .take_i      (take),
    .item_i      (held_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mpfp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_o     (out_ready),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .res_o       (out_res)
  );

  assign m_axis_tdata_o = {{(mpfp_pkg::OutDataWidth - mpfp_pkg::PosWidth){1'b0}},
                           out_res.position_tenths};
  assign m_axis_tuser_o = out_res.status;

  // Input side only stalls behind a stalled, full result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i))
    else $error("input stalled without a stalled result");

  // Timeout results carry a zero position
  a_timeout_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o[0] == mpfp_pkg::STATUS_TIMEOUT))
      |-> (m_axis_tdata_o[32:0] == 33'd0))
    else $error("timeout result with nonzero position");

  // Result only appears after an item was held for processing
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(held_valid))
    else $error("result without a processed item");

endmodule

// ===== test/testbench.sv =====
// Testbench: directed and random stream checks of the motor position frame parser.
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [7:0] CMD_MARK    = 8'h36;
  localparam logic [7:0] END_MARK    = 8'h6B;
  localparam int unsigned PHASE_ITEMS = 190;

  // One row of the directed plan; want is used only when typed is set
  typedef struct packed {
    logic [1:0]          kind;
    logic [7:0]          data;
    logic                typed;
    mpfp_pkg::result_t   want;
  } plan_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;    // [7:0] rx_byte
  logic [1:0]  s_tuser = '0;    // [1:0] func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;         // [32:0] position_tenths, [39:33] zero
  logic [0:0]  m_tuser;         // [0] status

  // Predictor copy of configuration and hunt state
  logic [7:0]  cfg_addr = mpfp_pkg::AddressReset;
  logic [15:0] cfg_limit = mpfp_pkg::TimeoutReset;
  logic        hunting = 1'b0;
  logic [2:0]  hunt_pos = '0;
  logic        neg_sign = 1'b0;
  logic [31:0] mag_acc = '0;
  logic [15:0] elapsed = '0;

  mpfp_pkg::result_t replies_due [$];
  bit          calm = 1'b0;
  int unsigned n_items = 0;
  int unsigned n_live = 0;
  int unsigned n_frames = 0;
  int unsigned n_timeouts = 0;
  int unsigned n_writes = 0;
  int unsigned n_bad = 0;

  motor_position_frame_parser i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard limit on run time
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic void drop_frame();
    hunt_pos = '0;
    neg_sign = 1'b0;
    mag_acc  = '0;
  endfunction

  // Advance the predicted hunt by one item; returns 1 when a result is due
  function automatic bit predict_reply(input logic [1:0] kind, input logic [7:0] b,
                                       output mpfp_pkg::result_t res);
    logic [32:0] mag;
    res = '0;
    if (kind == mpfp_pkg::FUNC_START) begin
      hunting = 1'b1;
      drop_frame();
      elapsed = '0;
      n_live++;
      return 1'b0;
    end
    if (!hunting || kind == KIND_UNUSED) return 1'b0;
    n_live++;
    if (kind == mpfp_pkg::FUNC_BYTE) begin
      case (hunt_pos)
        3'd0: if (b == cfg_addr) hunt_pos = 3'd1;
        3'd1: begin
          if (b == CMD_MARK) hunt_pos = 3'd2;
          else hunt_pos = (b == cfg_addr) ? 3'd1 : 3'd0;
        end
        3'd2: begin
          neg_sign = (b != 8'h00);
          hunt_pos = 3'd3;
        end
        3'd3, 3'd4, 3'd5, 3'd6: begin
          mag_acc  = {mag_acc[23:0], b};
          hunt_pos = hunt_pos + 3'd1;
        end
        default: begin
          // Terminator: good one ends the search, bad one only drops the frame
          if (b == END_MARK) begin
            mag = {1'b0, mag_acc};
            res.status = mpfp_pkg::STATUS_FRAME;
            res.position_tenths = neg_sign ? -mag : mag;
            hunting = 1'b0;
            drop_frame();
            return 1'b1;
          end
          drop_frame();
        end
      endcase
      return 1'b0;
    end
    // Millisecond tick, counter saturates
    if (elapsed != 16'hFFFF) elapsed = elapsed + 16'd1;
    if (elapsed >= cfg_limit) begin
      res.status = mpfp_pkg::STATUS_TIMEOUT;
      res.position_tenths = '0;
      hunting = 1'b0;
      drop_frame();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Offer one item, wait for the handshake, then predict
  task automatic send_item(input logic [1:0] kind, input logic [7:0] b,
                           input logic typed = 1'b0,
                           input mpfp_pkg::result_t want = '0);
    mpfp_pkg::result_t res;
    bit      due;
    if (!calm) begin
      while ($urandom_range(99) < 24) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_items++;
    due = predict_reply(kind, b, res);
    if (typed) replies_due.push_back(want);
    else if (due) replies_due.push_back(res);
  endtask

  // Stop sending and let every expected result drain out
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == mpfp_pkg::CFG_DEVICE_ADDRESS) cfg_addr = val[7:0];
    else cfg_limit = val;
    n_writes++;
    @(posedge clk);
  endtask

  // Random traffic: mostly reply frames with random content, some broken
  task automatic run_phase(input int unsigned quota);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    int unsigned r;
    logic [7:0]  fr [8];
    stop_at = n_items + quota;
    while (n_items < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        if ($urandom_range(4) != 0)
          send_item(mpfp_pkg::FUNC_START, 8'($urandom_range(255)));
        repeat ($urandom_range(2)) send_item(mpfp_pkg::FUNC_BYTE, 8'($urandom_range(255)));
        fr[0] = ($urandom_range(9) != 0) ? cfg_addr : 8'($urandom_range(255));
        r = $urandom_range(19);
        fr[1] = (r < 16) ? CMD_MARK : (r < 18) ? cfg_addr : 8'($urandom_range(255));
        fr[2] = $urandom_range(1) ? 8'h00 : 8'($urandom_range(255));
        for (int i = 3; i < 7; i++) begin
          r = $urandom_range(9);
          fr[i] = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(255));
        end
        fr[7] = ($urandom_range(9) != 0) ? END_MARK : 8'($urandom_range(255));
        len = ($urandom_range(9) == 0) ? $urandom_range(1, 7) : 8;
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(99) < 6)
            send_item(mpfp_pkg::FUNC_TICK, 8'($urandom_range(255)));
          send_item(mpfp_pkg::FUNC_BYTE, fr[i]);
        end
      end else if (pick < 80) begin
        // Tick burst, reaches the timeout when the limit is small
        if ($urandom_range(1)) send_item(mpfp_pkg::FUNC_START, 8'($urandom_range(255)));
        repeat ($urandom_range(1, 6))
          send_item(mpfp_pkg::FUNC_TICK, 8'($urandom_range(255)));
      end else begin
        send_item(2'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end
  endtask

  // Output side stalls at random outside the calm stretch
  always @(posedge clk) begin
    m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 24);
  end

  // Result checker
  always @(posedge clk) begin
    mpfp_pkg::result_t want;
    if (rst_n && m_tvalid && m_tready) begin
      if (m_tuser[0] == mpfp_pkg::STATUS_TIMEOUT) n_timeouts++;
      else n_frames++;
      if (replies_due.size() == 0) begin
        if (n_bad < 10)
          $display("unexpected result: status %0d position %0d", m_tuser[0],
                   $signed(m_tdata[32:0]));
        n_bad++;
      end else begin
        want = replies_due.pop_front();
        if (m_tuser[0] !== want.status || m_tdata !== {7'b0, want.position_tenths}) begin
          if (n_bad < 10)
            $display("mismatch: status exp %0d got %0d, tdata exp %h got %h (pos %0d / %0d)",
                     want.status, m_tuser[0], {7'b0, want.position_tenths}, m_tdata,
                     want.position_tenths, $signed(m_tdata[32:0]));
          n_bad++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    plan_row_t   plan [26];
    logic [7:0]  addrs [7];
    logic [15:0] limits [7];

    plan = '{
      '{mpfp_pkg::FUNC_TICK,  8'h00, 1'b0, '0},  // idle: ignored
      '{KIND_UNUSED,          8'hFF, 1'b0, '0},  // unused kind: ignored
      '{mpfp_pkg::FUNC_START, 8'h00, 1'b0, '0},
      '{mpfp_pkg::FUNC_BYTE,  8'h01, 1'b0, '0},
      '{mpfp_pkg::FUNC_BYTE,  8'h36, 1'b0, '0},
      '{mpfp_pkg::FUNC_BYTE,  8'h05, 1'b0, '0},
      '{mpfp_pkg::FUNC_BYTE,  8'h12, 1'b0, '0},
      '{mpfp_pkg::FUNC_START, 8'hA5, 1'b0, '0},  // restart mid-frame
      '{mpfp_pkg::FUNC_BYTE,  8'h01, 1'b0, '0},
      '{mpfp_pkg::FUNC_BYTE,  8'h01, 1'b0, '0},  // address again holds second position
      '{mpfp_pkg::FUNC_BYTE,  8'h36, 1'b0, '0},
      '{mpfp_pkg::FUNC_BYTE,  8'hFF, 1'b0, '0},
      '{mpfp_pkg::FUNC_BYTE,  8'hFF, 1'b0, '0},
      '{mpfp_pkg::FUNC_BYTE,  8'hFF, 1'b0, '0},
      '{mpfp_pkg::FUNC_BYTE,  8'hFF, 1'b0, '0},
      '{mpfp_pkg::FUNC_BYTE,  8'hFF, 1'b0, '0},
      // most negative
      '{mpfp_pkg::FUNC_BYTE,  8'h6B, 1'b1, '{mpfp_pkg::STATUS_FRAME, 33'h1_0000_0001}},
      '{mpfp_pkg::FUNC_BYTE,  8'h01, 1'b0, '0},  // idle again: ignored
      '{mpfp_pkg::FUNC_START, 8'h00, 1'b0, '0},
      '{mpfp_pkg::FUNC_BYTE,  8'h01, 1'b0, '0},
      '{mpfp_pkg::FUNC_BYTE,  8'h36, 1'b0, '0},
      '{mpfp_pkg::FUNC_BYTE,  8'h00, 1'b0, '0},
      '{mpfp_pkg::FUNC_BYTE,  8'hFF, 1'b0, '0},
      '{mpfp_pkg::FUNC_BYTE,  8'hFF, 1'b0, '0},
      '{mpfp_pkg::FUNC_BYTE,  8'hFF, 1'b0, '0},
      '{mpfp_pkg::FUNC_BYTE,  8'hFF, 1'b0, '0}
    };
    addrs  = '{8'h00, 8'hFF, 8'h36, 8'h6B, 8'($urandom_range(255)), 8'($urandom_range(255)),
               mpfp_pkg::AddressReset};
    limits = '{16'd0, 16'hFFFF, 16'd3, 16'd1, 16'($urandom_range(2, 30)),
               16'($urandom_range(1, 12)), mpfp_pkg::TimeoutReset};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed plan under reset configuration
    foreach (plan[i]) send_item(plan[i].kind, plan[i].data, plan[i].typed, plan[i].want);
    // most positive
    send_item(mpfp_pkg::FUNC_BYTE, END_MARK, 1'b1,
              '{mpfp_pkg::STATUS_FRAME, 33'h0_FFFF_FFFF});
    wait_idle();
    // Zero limit: first tick times out
    write_reg(mpfp_pkg::CFG_TIMEOUT_LIMIT, 16'd0);
    send_item(mpfp_pkg::FUNC_START, 8'h00);
    send_item(mpfp_pkg::FUNC_TICK, 8'h00, 1'b1, '{mpfp_pkg::STATUS_TIMEOUT, 33'h0});

    // Random phases, each under its own configuration
    foreach (addrs[p]) begin
      wait_idle();
      write_reg(mpfp_pkg::CFG_DEVICE_ADDRESS, {8'h00, addrs[p]});
      write_reg(mpfp_pkg::CFG_TIMEOUT_LIMIT, limits[p]);
      calm = (p == 2);
      run_phase(PHASE_ITEMS);
    end
    calm = 1'b0;
    wait_idle();
    repeat (4) @(posedge clk);

    $display("covered %0d items (%0d acted on), %0d frames, %0d timeouts, %0d register writes",
             n_items, n_live, n_frames, n_timeouts, n_writes);
    $display("mismatches: %0d", n_bad);
    if (n_bad == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
